>>> rtl/hsha_pkg.sv
// Shared types, constants and round tables for the HMAC-SHA-256 engine.
package hsha_pkg;

  typedef logic [7:0][31:0]  hsha_state_t;
  typedef logic [15:0][31:0] hsha_block_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hsha_core_stat_t;

  localparam logic [7:0] KEY_IPAD  = 8'h36;
  localparam logic [7:0] KEY_OPAD  = 8'h5c;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_SLOT  = 6'd56;
  localparam logic [6:0] KEY_BYTES = 7'd64;

  function automatic logic [31:0] hsha_iv(input logic [2:0] idx);
    logic [31:0] r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] hsha_rk(input logic [5:0] idx);
    logic [31:0] r;
    unique case (idx)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491; 6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5; 6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5; 6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/hsha_if.sv
// Valid/ready channel interfaces for the HMAC-SHA-256 engine.
interface hsha_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;
  modport source (output valid, action, data_byte, byte_valid, last_byte, input ready);
  modport sink   (input valid, action, data_byte, byte_valid, last_byte, output ready);
endinterface

interface hsha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] mac_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, mac_word, word_index, last_word, input ready);
  modport sink   (input valid, mac_word, word_index, last_word, output ready);
endinterface

>>> rtl/hsha_core.sv
// SHA-256 compression unit: one round per cycle over a rolling schedule window.
module hsha_core import hsha_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  hsha_block_t     blk,
  input  hsha_state_t     chain,
  output hsha_state_t     vars,
  output hsha_core_stat_t stat
);

  hsha_state_t      v_r;
  logic [15:0][31:0] w_r;
  logic [5:0]       rnd_r;
  logic             busy_r;
  logic             done_r;

  logic [31:0] t1, t2, wn, e, a;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    e  = v_r[4];
    a  = v_r[0];
    t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & v_r[5]) ^ (~e & v_r[6])) + hsha_rk(rnd_r) + w_r[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
    wn = w_r[0] + (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3)) + w_r[9]
       + (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= chain;
        for (int i = 0; i < 16; i++) w_r[i] <= blk[15 - i];
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
        w_r[15] <= wn;
        rnd_r   <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign vars      = v_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> rtl/hmac_sha256_engine.sv
// HMAC-SHA-256 engine top level: byte sequencer, key store and result port.
// Takes one input transaction at a time; ready is high only when the sequencer
// is idle. A message byte passes through accept, dispatch, load into the block
// register and dispatch; a key byte that fits the key store through accept and
// dispatch. Every 64 loaded bytes run the shared round unit (start, 64 rounds,
// chain fold). The first message item also loads the inner pad block (64
// padded key bytes plus one compression); a key past 64 bytes first loads
// the 64 stored bytes. The last message item runs inner padding, the outer
// pad block, the inner digest and outer padding, then eight result
// transactions, one per accepted output cycle.
module hmac_sha256_engine import hsha_pkg::*; #(
  parameter int LENGTH_BITS = 64
) (
  input logic         clk,
  input logic         rst_n,
  hsha_in_if.sink     in_chan,
  hsha_out_if.source  out_chan
);

  localparam int TotW = LENGTH_BITS - 3;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_DUMP, S_IPAD, S_OPAD, S_BYTE, S_PAD80,
    S_PADZ, S_LEN, S_DIG, S_COMP, S_FIN, S_OUT
  } state_t;

  typedef enum logic [1:0] { P_IDLE, P_KEY, P_MSG } phase_t;
  typedef enum logic [1:0] { F_KEY, F_INNER, F_OUTER } fin_t;

  state_t       state_r, ret_r;
  phase_t       phase_r;
  fin_t         fin_r;
  logic [7:0]   key_r [64];
  logic [6:0]   key_count_r;
  logic         too_long_r;
  logic [511:0] blk_r;
  logic [5:0]   fill_r;
  logic [TotW-1:0] tot_r;
  logic [63:0]  len_r;
  hsha_state_t  chain_r;
  logic [255:0] dig_r;
  logic [5:0]   cnt_r;
  logic [2:0]   out_idx_r;
  logic         go_r;
  logic         fk_pre_r, dump_r, ipad_r, byte_r, fk_post_r, msgfin_r;
  logic [7:0]   byte_val_r;

  logic            feed_en;
  logic [7:0]      feed_b;
  logic            blk_full;
  logic            acc;
  hsha_state_t     core_vars;
  hsha_core_stat_t core_stat;

  hsha_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .blk   (blk_r),
    .chain (chain_r),
    .vars  (core_vars),
    .stat  (core_stat)
  );

  assign in_chan.ready       = (state_r == S_IDLE);
  assign acc                 = in_chan.valid && in_chan.ready;
  assign out_chan.valid      = (state_r == S_OUT);
  assign out_chan.mac_word   = dig_r[255:224];
  assign out_chan.word_index = out_idx_r;
  assign out_chan.last_word  = (out_idx_r == 3'd7);

  always_comb begin
    feed_en = 1'b1;
    feed_b  = 8'h00;
    unique case (state_r)
      S_DUMP:  feed_b = key_r[0];
      S_IPAD:  feed_b = key_r[0] ^ KEY_IPAD;
      S_OPAD:  feed_b = key_r[0] ^ KEY_OPAD;
      S_BYTE:  feed_b = byte_val_r;
      S_PAD80: feed_b = PAD_BYTE;
      S_PADZ:  feed_b = 8'h00;
      S_LEN:   feed_b = len_r[63:56];
      S_DIG:   feed_b = dig_r[255:248];
      default: feed_en = 1'b0;
    endcase
  end

  assign blk_full = feed_en && (fill_r == 6'd63);

  always_ff @(posedge clk) begin
    state_t     nx;
    logic       long_eff;
    logic [6:0] cnt_eff;
    logic       key_wr;
    nx       = state_r;
    long_eff = (phase_r == P_KEY) && too_long_r;
    cnt_eff  = (phase_r == P_KEY) ? key_count_r : 7'd0;
    key_wr   = in_chan.byte_valid && !long_eff && (cnt_eff < KEY_BYTES);
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      phase_r     <= P_IDLE;
      fin_r       <= F_KEY;
      key_count_r <= '0;
      too_long_r  <= 1'b0;
      fill_r      <= '0;
      tot_r       <= '0;
      cnt_r       <= '0;
      out_idx_r   <= '0;
      go_r        <= 1'b0;
      fk_pre_r    <= 1'b0;
      dump_r      <= 1'b0;
      ipad_r      <= 1'b0;
      byte_r      <= 1'b0;
      fk_post_r   <= 1'b0;
      msgfin_r    <= 1'b0;
      for (int i = 0; i < 64; i++) key_r[i] <= '0;
      for (int i = 0; i < 8; i++) chain_r[i] <= hsha_iv(3'(i));
    end else begin
      if (feed_en) begin
        blk_r  <= {blk_r[503:0], feed_b};
        fill_r <= fill_r + 6'd1;
        tot_r  <= tot_r + 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            nx         = S_DISP;
            byte_val_r <= in_chan.data_byte;
            if (!in_chan.action) begin
              for (int i = 0; i < 64; i++) begin
                if (key_wr && cnt_eff[5:0] == 6'(i)) key_r[i] <= in_chan.data_byte;
                else if (phase_r != P_KEY) key_r[i] <= '0;
              end
              key_count_r <= key_wr ? cnt_eff + 7'd1 : cnt_eff;
              too_long_r  <= long_eff || (in_chan.byte_valid && !key_wr);
              if (in_chan.byte_valid && !key_wr) begin
                byte_r <= 1'b1;
                if (!long_eff) dump_r <= 1'b1;
              end
              fk_post_r <= in_chan.last_byte &&
                           (long_eff || (in_chan.byte_valid && cnt_eff == KEY_BYTES));
              phase_r   <= in_chan.last_byte ? P_IDLE : P_KEY;
            end else begin
              fk_pre_r <= (phase_r == P_KEY) && too_long_r;
              ipad_r   <= (phase_r != P_MSG);
              byte_r   <= in_chan.byte_valid;
              msgfin_r <= in_chan.last_byte;
              phase_r  <= in_chan.last_byte ? P_IDLE : P_MSG;
            end
          end
        end
        S_DISP: begin
          priority if (fk_pre_r) begin
            fk_pre_r <= 1'b0;
            fin_r    <= F_KEY;
            nx       = S_PAD80;
          end else if (dump_r) begin
            dump_r <= 1'b0;
            for (int i = 0; i < 8; i++) chain_r[i] <= hsha_iv(3'(i));
            fill_r <= '0;
            tot_r  <= '0;
            cnt_r  <= '0;
            nx     = S_DUMP;
          end else if (ipad_r) begin
            ipad_r <= 1'b0;
            for (int i = 0; i < 8; i++) chain_r[i] <= hsha_iv(3'(i));
            fill_r <= '0;
            tot_r  <= '0;
            cnt_r  <= '0;
            nx     = S_IPAD;
          end else if (byte_r) begin
            byte_r <= 1'b0;
            nx     = S_BYTE;
          end else if (fk_post_r) begin
            fk_post_r <= 1'b0;
            fin_r     <= F_KEY;
            nx        = S_PAD80;
          end else if (msgfin_r) begin
            msgfin_r <= 1'b0;
            fin_r    <= F_INNER;
            nx       = S_PAD80;
          end else begin
            nx = S_IDLE;
          end
        end
        S_DUMP, S_IPAD, S_OPAD: begin
          for (int i = 0; i < 63; i++) key_r[i] <= key_r[i + 1];
          key_r[63] <= key_r[0];
          cnt_r     <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            nx = (state_r == S_OPAD) ? S_DIG : S_DISP;
          end
        end
        S_BYTE: nx = S_DISP;
        S_PAD80: begin
          len_r <= 64'({tot_r, 3'b000});
          cnt_r <= '0;
          nx    = (fill_r == LEN_SLOT - 6'd1) ? S_LEN : S_PADZ;
        end
        S_PADZ: begin
          if (fill_r == LEN_SLOT - 6'd1) nx = S_LEN;
        end
        S_LEN: begin
          len_r <= {len_r[55:0], 8'h00};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd7) nx = S_FIN;
        end
        S_DIG: begin
          dig_r <= {dig_r[247:0], 8'h00};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) begin
            fin_r <= F_OUTER;
            nx    = S_PAD80;
          end
        end
        S_COMP: begin
          if (core_stat.done) begin
            for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + core_vars[i];
            nx = ret_r;
          end
        end
        S_FIN: begin
          unique case (fin_r)
            F_KEY: begin
              for (int i = 0; i < 32; i++) key_r[i] <= chain_r[i / 4][31 - 8 * (i % 4) -: 8];
              for (int i = 32; i < 64; i++) key_r[i] <= 8'h00;
              key_count_r <= 7'd32;
              too_long_r  <= 1'b0;
              nx          = S_DISP;
            end
            F_INNER: begin
              for (int i = 0; i < 8; i++) dig_r[255 - 32 * i -: 32] <= chain_r[i];
              for (int i = 0; i < 8; i++) chain_r[i] <= hsha_iv(3'(i));
              fill_r <= '0;
              tot_r  <= '0;
              cnt_r  <= '0;
              nx     = S_OPAD;
            end
            default: begin
              for (int i = 0; i < 8; i++) dig_r[255 - 32 * i -: 32] <= chain_r[i];
              out_idx_r <= '0;
              nx        = S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (out_chan.ready) begin
            dig_r     <= {dig_r[223:0], 32'h0};
            out_idx_r <= out_idx_r + 3'd1;
            if (out_idx_r == 3'd7) nx = S_DISP;
          end
        end
        default: nx = S_IDLE;
      endcase
      go_r <= blk_full;
      if (blk_full) begin
        ret_r   <= nx;
        state_r <= S_COMP;
      end else begin
        state_r <= nx;
      end
    end
  end

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !in_chan.ready)
    else $error("input ready while result pending");

  a_core_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    core_stat.busy |-> state_r == S_COMP)
    else $error("round unit busy outside compression wait");

  a_last_word_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.ready && out_chan.last_word |=> !out_chan.valid)
    else $error("result words continue past last word");

  a_key_count: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= KEY_BYTES)
    else $error("key count overflow");

endmodule
